// File: rtl/core/bpa_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and types of the bitmap page allocator
package bpa_pkg;

   localparam int MAX_PAGES = 1024;
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int IDX_W     = WORD_AW + BIT_W;

   // fixed field widths
   localparam int COUNT_W  = 11;
   localparam int PAGE_W   = 20;
   localparam int POOL_W   = 11;
   localparam int STATUS_W = 3;
   localparam int CSR_W    = 32;
   localparam int ADDR_W   = 3;

   // run lengths, sizes and run starts
   localparam int POS_W  = IDX_W + 1;
   localparam int CALC_W = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic REG_POOL_PAGES = 1'b0;
   localparam logic REG_BASE_PAGE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_PAGES    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO_COUNT  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREED_UNUSED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 3'd4;

   typedef struct packed {
      logic              hit;
      logic [BIT_W-1:0]  pos;
      logic [CALC_W-1:0] run_out;
   } bpa_scan_type;

endpackage

// File: rtl/core/bpa_run_finder.sv
`timescale 1ns / 1ps
// one-word free run finder shared by every step of the allocation scan
module bpa_run_finder (
   input  logic [bpa_pkg::WORD_BITS-1:0] used_word,
   input  logic [bpa_pkg::CALC_W-1:0]    run_in,
   input  logic [bpa_pkg::CALC_W-1:0]    need,
   output bpa_pkg::bpa_scan_type         scan
);

   logic [bpa_pkg::CALC_W-1:0]    run_at [bpa_pkg::WORD_BITS];
   logic [bpa_pkg::WORD_BITS-1:0] hit_at;

   // free run length ending at each bit, carried in from earlier words
   always_comb begin : run_lengths
      logic                      seen;
      logic [bpa_pkg::BIT_W-1:0] last;
      for (int j = 0; j < bpa_pkg::WORD_BITS; j++) begin
         seen = 1'b0;
         last = '0;
         for (int k = 0; k <= j; k++) begin
            if (used_word[k]) begin
               seen = 1'b1;
               last = bpa_pkg::BIT_W'(k);
            end
         end
         if (seen) begin
            run_at[j] = bpa_pkg::CALC_W'(bpa_pkg::BIT_W'(j) - last);
         end else begin
            run_at[j] = run_in + bpa_pkg::CALC_W'(j + 1);
         end
         hit_at[j] = (run_at[j] >= need);
      end
   end

   // lowest bit where the run first reaches the request
   always_comb begin
      scan.hit     = |hit_at;
      scan.pos     = '0;
      scan.run_out = run_at[bpa_pkg::WORD_BITS-1];
      for (int j = bpa_pkg::WORD_BITS - 1; j >= 0; j--) begin
         if (hit_at[j]) begin
            scan.pos = bpa_pkg::BIT_W'(j);
         end
      end
   end

endmodule

// File: rtl/core/bitmap_page_allocator_unit.sv
`timescale 1ns / 1ps
// first-fit bitmap page allocator: csr block, sequencer and used-page map
//
//   channel   ports                         handshake
//   request   req_mode, req_page_count,     beat taken when start high, busy low
//             req_page_number
//   response  rsp_status, rsp_granted_page  beat valid for one cycle with rsp_strobe
//   csr       psel, penable, pwrite, paddr, write taken with penable, pready tied high
//             pwdata, prdata, pready
//
// a zero count, an oversized allocate or an out-of-range free is answered from S_DECIDE
// a free goes through S_DECIDE, then a read (S_RMW_RD) and a write (S_RMW_WR) per map word it touches
// an allocate goes through S_DECIDE and a first-fit scan in S_SCAN (one 32-bit map word per cycle
//   through the shared run finder, up to 32 words), then a read and a write per word to mark the run
// reset clears the csr and one valid flag per map word, so no clearing pass runs
// busy stays high from the request beat up to the response beat; the response
//   cannot be stalled and start is taken again in the cycle of rsp_strobe
module bitmap_page_allocator_unit (
   input  logic                            clock,
   input  logic                            reset,
   // request
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_mode,
   input  logic [bpa_pkg::COUNT_W-1:0]     req_page_count,
   input  logic [bpa_pkg::PAGE_W-1:0]      req_page_number,
   // response
   output logic                            rsp_strobe,
   output logic [bpa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bpa_pkg::PAGE_W-1:0]      rsp_granted_page,
   // csr
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bpa_pkg::ADDR_W-1:0]      paddr,
   input  logic [bpa_pkg::CSR_W-1:0]       pwdata,
   output logic [bpa_pkg::CSR_W-1:0]       prdata,
   output logic                            pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_RMW_RD,
      S_RMW_WR
   } state_type;

   // csr
   logic [bpa_pkg::POOL_W-1:0] pool_pages_ff;
   logic [bpa_pkg::PAGE_W-1:0] base_page_ff;
   logic                       csr_write;

   // sequencer
   state_type                      state_ff, state_in;
   logic                           mode_ff, mode_in;
   logic [bpa_pkg::COUNT_W-1:0]    count_ff, count_in;
   logic [bpa_pkg::PAGE_W-1:0]     page_ff, page_in;
   logic [bpa_pkg::CALC_W-1:0]     size_ff, size_in;
   logic [bpa_pkg::WORD_AW-1:0]    word_ff, word_in;
   logic [bpa_pkg::IDX_W-1:0]      lo_ff, lo_in;
   logic [bpa_pkg::IDX_W-1:0]      hi_ff, hi_in;
   logic [bpa_pkg::CALC_W-1:0]     run_ff, run_in;
   logic                           unused_ff, unused_in;
   logic                           rsp_strobe_ff, rsp_strobe_in;
   logic [bpa_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [bpa_pkg::PAGE_W-1:0]     rsp_granted_ff, rsp_granted_in;

   // used-page map, one word per entry, with a valid flag per word
   logic [bpa_pkg::WORD_BITS-1:0] map_mem [bpa_pkg::MAP_WORDS];
   logic [bpa_pkg::MAP_WORDS-1:0] valid_ff;
   logic [bpa_pkg::WORD_BITS-1:0] rd_data_ff;
   logic                          rd_vld_ff;
   logic [bpa_pkg::WORD_AW-1:0]   rd_addr;
   logic                          mem_we;
   logic [bpa_pkg::WORD_BITS-1:0] mem_wdata;
   logic [bpa_pkg::WORD_BITS-1:0] rd_word;

   // scan datapath
   logic [bpa_pkg::CALC_W-1:0]    word_base;
   logic [bpa_pkg::CALC_W-1:0]    pool_left;
   logic [bpa_pkg::WORD_BITS-1:0] pool_mask;
   logic [bpa_pkg::WORD_BITS-1:0] scan_used;
   bpa_pkg::bpa_scan_type         scan;

   // run bit mask within the current word
   logic [bpa_pkg::BIT_W-1:0]     lo_bit, hi_bit;
   logic [bpa_pkg::WORD_BITS-1:0] run_mask;

   // free range check
   logic [bpa_pkg::PAGE_W-1:0] free_idx;
   logic [bpa_pkg::PAGE_W:0]   free_top;
   logic [bpa_pkg::IDX_W-1:0]  hit_idx;
   logic [bpa_pkg::CALC_W-1:0] hit_start;

   //---------------------------------------------------------------- csr block
   assign csr_write = psel & penable & pwrite & pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_pages_ff <= '0;
         base_page_ff  <= '0;
      end else if (csr_write) begin
         unique case (paddr[2])
            bpa_pkg::REG_POOL_PAGES: pool_pages_ff <= pwdata[bpa_pkg::POOL_W-1:0];
            bpa_pkg::REG_BASE_PAGE:  base_page_ff  <= pwdata[bpa_pkg::PAGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         bpa_pkg::REG_POOL_PAGES: prdata = bpa_pkg::CSR_W'(pool_pages_ff);
         bpa_pkg::REG_BASE_PAGE:  prdata = bpa_pkg::CSR_W'(base_page_ff);
         default:                 prdata = '0;
      endcase
   end

   //---------------------------------------------------------------- map memory
   // unwritten words read back as all free
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[word_ff] <= mem_wdata;
      end
      rd_data_ff <= map_mem[rd_addr];
      rd_vld_ff  <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[word_ff] <= 1'b1;
      end
   end

   assign rd_word = rd_data_ff & {bpa_pkg::WORD_BITS{rd_vld_ff}};

   //---------------------------------------------------------------- scan datapath
   // pages at or above the pool size count as used so no run crosses the end
   assign word_base = bpa_pkg::CALC_W'({word_ff, {bpa_pkg::BIT_W{1'b0}}});
   assign pool_left = size_ff - word_base;

   always_comb begin
      for (int j = 0; j < bpa_pkg::WORD_BITS; j++) begin
         pool_mask[j] = (bpa_pkg::CALC_W'(j) < pool_left);
      end
   end

   assign scan_used = rd_word | ~pool_mask;

   bpa_run_finder u_finder (
      .used_word (scan_used),
      .run_in    (run_ff),
      .need      (bpa_pkg::CALC_W'(count_ff)),
      .scan      (scan)
   );

   assign hit_idx   = {word_ff, scan.pos};
   assign hit_start = bpa_pkg::CALC_W'(hit_idx) + bpa_pkg::CALC_W'(1)
                      - bpa_pkg::CALC_W'(count_ff);

   // bits of the run that fall in the current word
   assign lo_bit = (word_ff == lo_ff[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W])
                   ? lo_ff[bpa_pkg::BIT_W-1:0] : '0;
   assign hi_bit = (word_ff == hi_ff[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W])
                   ? hi_ff[bpa_pkg::BIT_W-1:0] : '1;

   always_comb begin
      for (int j = 0; j < bpa_pkg::WORD_BITS; j++) begin
         run_mask[j] = (bpa_pkg::BIT_W'(j) >= lo_bit) && (bpa_pkg::BIT_W'(j) <= hi_bit);
      end
   end

   assign mem_wdata = (mode_ff == bpa_pkg::MODE_FREE) ? (rd_word & ~run_mask)
                                                      : (rd_word | run_mask);

   // free request offset into the pool
   assign free_idx = page_ff - base_page_ff;
   assign free_top = (bpa_pkg::PAGE_W + 1)'(free_idx) + (bpa_pkg::PAGE_W + 1)'(count_ff);

   //---------------------------------------------------------------- sequencer
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      count_in       = count_ff;
      page_in        = page_ff;
      size_in        = size_ff;
      word_in        = word_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      run_in         = run_ff;
      unused_in      = unused_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rd_addr        = word_ff;
      mem_we         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               count_in = req_page_count;
               page_in  = req_page_number;
               // oversized pool saturates to the map size
               if (bpa_pkg::CALC_W'(pool_pages_ff) > bpa_pkg::CALC_W'(bpa_pkg::MAX_PAGES)) begin
                  size_in = bpa_pkg::CALC_W'(bpa_pkg::MAX_PAGES);
               end else begin
                  size_in = bpa_pkg::CALC_W'(pool_pages_ff);
               end
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            rd_addr   = '0;
            unused_in = 1'b0;
            run_in    = '0;
            word_in   = '0;
            if (count_ff == '0) begin
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = bpa_pkg::ST_ZERO_COUNT;
               rsp_granted_in = '0;
               state_in       = S_IDLE;
            end else if (mode_ff == bpa_pkg::MODE_ALLOC) begin
               if (bpa_pkg::CALC_W'(count_ff) > size_ff) begin
                  rsp_strobe_in  = 1'b1;
                  rsp_status_in  = bpa_pkg::ST_NO_PAGES;
                  rsp_granted_in = '0;
                  state_in       = S_IDLE;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               if ((page_ff < base_page_ff) ||
                   (free_top > (bpa_pkg::PAGE_W + 1)'(size_ff))) begin
                  rsp_strobe_in  = 1'b1;
                  rsp_status_in  = bpa_pkg::ST_OUT_OF_RANGE;
                  rsp_granted_in = '0;
                  state_in       = S_IDLE;
               end else begin
                  lo_in    = free_idx[bpa_pkg::IDX_W-1:0];
                  hi_in    = bpa_pkg::IDX_W'(free_top - (bpa_pkg::PAGE_W + 1)'(1));
                  word_in  = free_idx[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W];
                  state_in = S_RMW_RD;
               end
            end
         end

         S_SCAN: begin
            // fetch the next word while this one goes through the finder
            rd_addr = word_ff + bpa_pkg::WORD_AW'(1);
            if (scan.hit) begin
               lo_in    = hit_start[bpa_pkg::IDX_W-1:0];
               hi_in    = hit_idx;
               word_in  = hit_start[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W];
               state_in = S_RMW_RD;
            end else if (word_base + bpa_pkg::CALC_W'(bpa_pkg::WORD_BITS) >= size_ff) begin
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = bpa_pkg::ST_NO_PAGES;
               rsp_granted_in = '0;
               state_in       = S_IDLE;
            end else begin
               word_in = word_ff + bpa_pkg::WORD_AW'(1);
               run_in  = scan.run_out;
            end
         end

         S_RMW_RD: begin
            state_in = S_RMW_WR;
         end

         S_RMW_WR: begin
            mem_we = 1'b1;
            if (mode_ff == bpa_pkg::MODE_FREE) begin
               unused_in = unused_ff | (|(run_mask & ~rd_word));
            end
            if (word_ff == hi_ff[bpa_pkg::IDX_W-1:bpa_pkg::BIT_W]) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
               if (mode_ff == bpa_pkg::MODE_FREE) begin
                  rsp_status_in  = unused_in ? bpa_pkg::ST_FREED_UNUSED : bpa_pkg::ST_OK;
                  rsp_granted_in = '0;
               end else begin
                  rsp_status_in  = bpa_pkg::ST_OK;
                  rsp_granted_in = base_page_ff + bpa_pkg::PAGE_W'(lo_ff);
               end
            end else begin
               word_in  = word_ff + bpa_pkg::WORD_AW'(1);
               state_in = S_RMW_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      count_ff       <= count_in;
      page_ff        <= page_in;
      size_ff        <= size_in;
      word_ff        <= word_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      run_ff         <= run_in;
      unused_ff      <= unused_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_page = rsp_granted_ff;

`ifndef SYNTHESIS
   // a taken request keeps the block busy in the next cycle
   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request beat did not make the block busy");

   // every response closes work that was in flight
   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response beat without a request in flight");

   // the block goes idle only by answering
   a_idle_only_by_answer: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("block went idle without a response beat");

   // failures never carry a page (frees also answer with zero, not checked here)
   a_granted_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != bpa_pkg::ST_OK)) |-> (rsp_granted_page == '0))
      else $error("granted page set on a failed response");
`endif

endmodule
